FILE: src/scc_pkg.sv
package scc_pkg;

   localparam int MAP_SIZE_DEF = 512;
   localparam int CRD_W = 14;
   localparam int FLD_W = 9;
   localparam logic [7:0] THRESH_RESET = 8'd250;
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;
   localparam int QUEUE_DEPTH = 2;

   typedef logic signed [CRD_W-1:0] crd_type;

   typedef struct packed {
      logic [FLD_W-1:0] a0;
      logic [FLD_W-1:0] b0;
      logic [FLD_W-1:0] a1;
      logic [FLD_W-1:0] b1;
   } pass_type;

   typedef struct packed {
      logic             is_query;
      logic             wr_ok;
      logic             wr_obst;
      logic [FLD_W-1:0] wr_row;
      logic [FLD_W-1:0] wr_col;
      logic             blocked_now;
      pass_type         row_pass;
      pass_type         col_pass;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_RD1,
      ST_RD2,
      ST_CHK,
      ST_DONE
   } back_state_type;

endpackage

FILE: src/scc_ram.sv
module scc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: src/scc_front.sv
module scc_front #(
   parameter int MAP_SIZE = scc_pkg::MAP_SIZE_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [79:0]         req_tdata,
   input  logic                req_tuser,
   input  logic                queue_full,
   output logic                push,
   output scc_pkg::entry_type  push_entry
);
   import scc_pkg::*;

   logic [7:0]       thresh_ff, thresh_in;
   logic [FLD_W-1:0] p_row, p_col, r1, c1, r2, c2;
   logic [7:0]       blue, green, red;
   localparam logic [CRD_W-1:0] MAP_LIM = CRD_W'(MAP_SIZE);

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   assign thresh_in = csr_wr_en ? csr_wr_data : thresh_ff;

   assign p_row = req_tdata[8:0];
   assign p_col = req_tdata[17:9];
   assign blue  = req_tdata[25:18];
   assign green = req_tdata[33:26];
   assign red   = req_tdata[41:34];
   assign r1    = req_tdata[50:42];
   assign c1    = req_tdata[59:51];
   assign r2    = req_tdata[68:60];
   assign c2    = req_tdata[77:69];

   assign req_tready = !queue_full;
   assign push = req_tvalid && req_tready;

   always_comb begin
      push_entry = '0;
      push_entry.is_query = (req_tuser == KIND_QUERY);
      push_entry.wr_row = p_row;
      push_entry.wr_col = p_col;
      push_entry.wr_ok = ({{(CRD_W-FLD_W){1'b0}}, p_row} < MAP_LIM)
                      && ({{(CRD_W-FLD_W){1'b0}}, p_col} < MAP_LIM);
      push_entry.wr_obst = (blue < thresh_ff) && (green < thresh_ff) && (red < thresh_ff);
      push_entry.blocked_now = (r1 == r2);
      if (r1 < r2) begin
         push_entry.row_pass = '{a0: r1, b0: c1, a1: r2, b1: c2};
      end else begin
         push_entry.row_pass = '{a0: r2, b0: c2, a1: r1, b1: c1};
      end
      if (c1 <= c2) begin
         push_entry.col_pass = '{a0: c1, b0: r1, a1: c2, b1: r2};
      end else begin
         push_entry.col_pass = '{a0: c2, b0: r2, a1: c1, b1: r1};
      end
   end
endmodule

FILE: src/scc_queue.sv
module scc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  scc_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               full,
   output logic               empty,
   output scc_pkg::entry_type head
);
   import scc_pkg::*;

   entry_type slot_ff [QUEUE_DEPTH];
   logic [$clog2(QUEUE_DEPTH)-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [$clog2(QUEUE_DEPTH):0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= push_entry;
      end
   end

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + {{$clog2(QUEUE_DEPTH){1'b0}}, push}
                      - {{$clog2(QUEUE_DEPTH){1'b0}}, pop};
   end

   assign full  = (cnt_ff == ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rp_ff];
endmodule

FILE: src/scc_back.sv
module scc_back #(
   parameter int MAP_SIZE = scc_pkg::MAP_SIZE_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_empty,
   input  scc_pkg::entry_type head,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata
);
   import scc_pkg::*;

   localparam int CW = $clog2(MAP_SIZE);
   localparam int AW = 2 * CW;
   localparam logic signed [CRD_W-1:0] MAP_LIM = CRD_W'(MAP_SIZE);

   back_state_type   state_ff, state_in;
   entry_type        ent_ff, ent_in;
   logic             pass_ff, pass_in;
   logic [FLD_W-1:0] dq_ff, dq_in, drem_ff, drem_in, rd_ff, rd_in, rem_ff, rem_in;
   logic [FLD_W-1:0] a_ff, a_in;
   logic [3:0]       dcnt_ff, dcnt_in;
   crd_type          q_ff, q_in, qd_ff, qd_in;
   logic             clear_ff, clear_in;
   logic             rsp_valid_ff, rsp_valid_in, rsp_clear_ff, rsp_clear_in;

   pass_type         cur;
   logic [FLD_W-1:0] da;
   logic [FLD_W:0]   db, db_abs, trial, rem_sum;
   crd_type          m1, m2, row1, col1, row2, col2, a_crd;
   logic             on_map, last_step, out_free;
   logic             wr_en, mem_rd;
   logic [AW-1:0]    wr_addr, rd_addr;

   scc_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ent_in.wr_obst),
      .rd_addr (rd_addr),
      .rd_data (mem_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff       <= ent_in;
      pass_ff      <= pass_in;
      dq_ff        <= dq_in;
      drem_ff      <= drem_in;
      dcnt_ff      <= dcnt_in;
      rd_ff        <= rd_in;
      qd_ff        <= qd_in;
      rem_ff       <= rem_in;
      a_ff         <= a_in;
      q_ff         <= q_in;
      clear_ff     <= clear_in;
      rsp_clear_ff <= rsp_clear_in;
   end

   assign cur    = pass_ff ? ent_ff.col_pass : ent_ff.row_pass;
   assign da     = cur.a1 - cur.a0;
   assign db     = {1'b0, cur.b1} - {1'b0, cur.b0};
   assign db_abs = db[FLD_W] ? (~db + 1'b1) : db;
   assign trial  = {drem_ff, dq_ff[FLD_W-1]};
   assign rem_sum = {1'b0, rem_ff} + {1'b0, rd_ff};
   assign last_step = ({1'b0, a_ff} + 1'b1) >= {1'b0, cur.a1};

   assign a_crd = crd_type'({{(CRD_W-FLD_W){1'b0}}, a_ff});
   assign m1 = crd_type'({{(CRD_W-FLD_W){1'b0}}, cur.b0}) + q_ff;
   assign m2 = m1 + crd_type'(1);
   assign on_map = (a_crd < MAP_LIM) && (m1 >= 0) && (m2 < MAP_LIM);
   assign row1 = pass_ff ? m1 : a_crd;
   assign col1 = pass_ff ? a_crd : m1;
   assign row2 = pass_ff ? m2 : a_crd;
   assign col2 = pass_ff ? a_crd : m2;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign wr_addr = {ent_in.wr_row[CW-1:0], ent_in.wr_col[CW-1:0]};

   always_comb begin
      state_in     = state_ff;
      ent_in       = ent_ff;
      pass_in      = pass_ff;
      dq_in        = dq_ff;
      drem_in      = drem_ff;
      dcnt_in      = dcnt_ff;
      rd_in        = rd_ff;
      qd_in        = qd_ff;
      rem_in       = rem_ff;
      a_in         = a_ff;
      q_in         = q_ff;
      clear_in     = clear_ff;
      rsp_clear_in = rsp_clear_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pop          = 1'b0;
      wr_en        = 1'b0;
      rd_addr      = {row1[CW-1:0], col1[CW-1:0]};

      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop    = 1'b1;
               ent_in = head;
               if (!head.is_query) begin
                  wr_en = head.wr_ok;
               end else if (head.blocked_now) begin
                  clear_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  pass_in  = 1'b0;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            if (da <= FLD_W'(1)) begin
               if (!pass_ff) begin
                  pass_in = 1'b1;
               end else begin
                  clear_in = 1'b1;
                  state_in = ST_DONE;
               end
            end else begin
               dq_in    = db_abs[FLD_W-1:0];
               drem_in  = '0;
               dcnt_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (dcnt_ff == 4'(FLD_W)) begin
               a_in = cur.a0 + 1'b1;
               if (!db[FLD_W]) begin
                  qd_in = crd_type'({{(CRD_W-FLD_W){1'b0}}, dq_ff});
                  rd_in = drem_ff;
               end else if (drem_ff == '0) begin
                  qd_in = -crd_type'({{(CRD_W-FLD_W){1'b0}}, dq_ff});
                  rd_in = '0;
               end else begin
                  qd_in = -crd_type'({{(CRD_W-FLD_W){1'b0}}, dq_ff}) - crd_type'(1);
                  rd_in = da - drem_ff;
               end
               q_in     = qd_in;
               rem_in   = rd_in;
               state_in = ST_RD1;
            end else begin
               if (trial >= {1'b0, da}) begin
                  drem_in = FLD_W'(trial - {1'b0, da});
                  dq_in   = {dq_ff[FLD_W-2:0], 1'b1};
               end else begin
                  drem_in = trial[FLD_W-1:0];
                  dq_in   = {dq_ff[FLD_W-2:0], 1'b0};
               end
               dcnt_in = dcnt_ff + 1'b1;
            end
         end
         ST_RD1, ST_RD2, ST_CHK: begin
            if (state_ff == ST_RD1 && on_map) begin
               state_in = ST_RD2;
            end else if (state_ff == ST_RD2) begin
               rd_addr = {row2[CW-1:0], col2[CW-1:0]};
               if (mem_rd) begin
                  clear_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_CHK;
               end
            end else if (state_ff == ST_CHK && mem_rd) begin
               clear_in = 1'b0;
               state_in = ST_DONE;
            end else if (last_step) begin
               state_in = ST_SETUP;
               if (!pass_ff) begin
                  pass_in = 1'b1;
               end else begin
                  clear_in = 1'b1;
                  state_in = ST_DONE;
               end
            end else begin
               a_in = a_ff + 1'b1;
               if (rem_sum >= {1'b0, da}) begin
                  rem_in = FLD_W'(rem_sum - {1'b0, da});
                  q_in   = q_ff + qd_ff + crd_type'(1);
               end else begin
                  rem_in = rem_sum[FLD_W-1:0];
                  q_in   = q_ff + qd_ff;
               end
               state_in = ST_RD1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_clear_in = clear_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_clear_ff};

   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD1) |-> (rem_ff < da))
      else $error("walk remainder not below major span");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (dcnt_ff <= 4'(FLD_W)))
      else $error("divider step count overran");

   a_walk_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD1) |-> (a_ff > cur.a0) && (a_ff < cur.a1))
      else $error("walk left the open span of the pass");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_IDLE) && !queue_empty)
      else $error("queue popped outside idle");
endmodule

FILE: src/segment_collision_check.sv
// Line-of-sight checker over a one-bit obstacle map held in block memory.
// Input words arrive on the req_ stream. tuser selects the kind: a write
// word stores one map pixel, which is an obstacle when all three color
// bytes are below the threshold; a query word names two endpoints and
// yields one rsp_ word whose bit 0 is 1 when the segment is clear.
// The threshold is written through csr_wr_en and csr_wr_data.
// A front stage classifies words into a two-entry queue; the back stage
// executes them. A write is done in the idle state as it is popped. A query
// is popped and then runs, per pass (rows, then columns), a setup state, the
// slope divider when the pass has samples, and for each sampled row or
// column the reads of its two pixels, one at a time through the single map
// read port. Its result passes through the done state into the output
// register that drives rsp_tvalid.
// Reset empties the queue and the output register and sets the threshold
// to 250; the map contents are not cleared and hold garbage until written.
// When rsp_tready is low the result waits in the output register and the
// back stage stops at its next result; the queue takes words until full.
module segment_collision_check #(
   parameter int MAP_SIZE = scc_pkg::MAP_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pixel_row, pixel_col, blue_byte, green_byte, red_byte,
   // first_row, first_col, second_row, second_col
   input  logic [79:0] req_tdata,
   // kind
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // path_clear
   output logic [7:0]  rsp_tdata
);
   import scc_pkg::*;

   logic      push, pop, q_full, q_empty;
   entry_type push_entry, head;

   scc_front #(.MAP_SIZE(MAP_SIZE)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .queue_full  (q_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   scc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (head)
   );

   scc_back #(.MAP_SIZE(MAP_SIZE)) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (q_empty),
      .head        (head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );
endmodule

FILE: tb/sv/segment_collision_check_tb.sv
`timescale 1ns / 100ps

module segment_collision_check_tb;
   import scc_pkg::*;

   localparam int MAP_N = 512;
   localparam int IDLE_LIMIT = 40000;
   localparam int DRAIN_CYCLES = 40;
   localparam int TYPED_NONE = -1;

   typedef struct {
      logic kind;
      int   pr, pc, bb, gb, rb, fr, fc, sr, sc;
      int   typed;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;

   bit           obst_map[MAP_N*MAP_N];
   bit           written_map[MAP_N*MAP_N];
   int           threshold = THRESH_RESET;
   bit           clear_expected[$];
   int           fail_count = 0;
   int           word_count = 0;
   int           query_count = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           obst_pct = 5;
   int           idle_cycles = 0;
   int           hot_r[4];
   int           hot_c[4];
   bit           head_clear;
   stim_row_type dir_tab[$];

   segment_collision_check #(.MAP_SIZE(MAP_N)) dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic void add_row(stim_row_type row);
      dir_tab = {dir_tab, row};
   endfunction

   function automatic void add_expected(bit value);
      clear_expected = {clear_expected, value};
   endfunction

   function automatic logic [79:0] pack_word(int pr, int pc, int bb, int gb, int rb,
                                             int fr, int fc, int sr, int sc);
      logic [79:0] w;
      w = '0;
      w[8:0] = pr[8:0];
      w[17:9] = pc[8:0];
      w[25:18] = bb[7:0];
      w[33:26] = gb[7:0];
      w[41:34] = rb[7:0];
      w[50:42] = fr[8:0];
      w[59:51] = fc[8:0];
      w[68:60] = sr[8:0];
      w[77:69] = sc[8:0];
      return w;
   endfunction

   function automatic int floor_quot(int n, int d);
      int q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   function automatic int color_byte(bit want_obst, bit forced_high);
      if (forced_high) return $urandom_range(255, threshold);
      if (want_obst && threshold > 0) return $urandom_range(threshold - 1, 0);
      return $urandom_range(255);
   endfunction

   task automatic push_word(logic kind, logic [79:0] data, int typed);
      bit blk;
      int idx;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      word_count++;
      if (kind == KIND_WRITE) begin
         idx = data[8:0] * MAP_N + data[17:9];
         written_map[idx] = 1'b1;
         obst_map[idx] = (data[25:18] < threshold) && (data[33:26] < threshold)
                         && (data[41:34] < threshold);
      end else begin
         query_count++;
         scan_query(data[50:42], data[59:51], data[68:60], data[77:69], 1'b0, blk);
         if (typed >= 0) add_expected(typed[0]);
         else add_expected(!blk);
      end
   endtask

   task automatic ensure_pixel(int r, int c);
      bit want;
      int hi;
      if (!written_map[r*MAP_N + c]) begin
         want = ($urandom_range(99) < obst_pct);
         hi = want ? -1 : $urandom_range(2);
         push_word(KIND_WRITE, pack_word(r, c, color_byte(want, hi == 0),
                   color_byte(want, hi == 1), color_byte(want, hi == 2),
                   $urandom_range(511), $urandom_range(511),
                   $urandom_range(511), $urandom_range(511)), TYPED_NONE);
      end
   endtask

   // With fill set, every sampled pixel not yet written is written first;
   // otherwise the walk reports whether it meets an obstacle.
   task automatic scan_pass(int a0, int b0, int a1, int b1, bit rows_major,
                            bit fill, output bit hit);
      int m1;
      int r0, c0, r1, c1;
      hit = 1'b0;
      if (a1 - a0 <= 0) return;
      for (int a = a0 + 1; a < a1; a++) begin
         m1 = b0 + floor_quot((a - a0) * (b1 - b0), a1 - a0);
         if (a < 0 || a >= MAP_N || m1 < 0 || m1 + 1 >= MAP_N) continue;
         r0 = rows_major ? a : m1;
         c0 = rows_major ? m1 : a;
         r1 = rows_major ? a : m1 + 1;
         c1 = rows_major ? m1 + 1 : a;
         if (fill) begin
            ensure_pixel(r0, c0);
            ensure_pixel(r1, c1);
         end else if (obst_map[r0*MAP_N + c0] || obst_map[r1*MAP_N + c1]) begin
            hit = 1'b1;
            return;
         end
      end
   endtask

   task automatic scan_query(int r1, int c1, int r2, int c2, bit fill, output bit blocked);
      bit hit;
      blocked = 1'b0;
      if (r1 == r2) begin
         blocked = 1'b1;
         return;
      end
      if (r1 < r2) scan_pass(r1, c1, r2, c2, 1'b1, fill, hit);
      else scan_pass(r2, c2, r1, c1, 1'b1, fill, hit);
      blocked = hit;
      if (!blocked || fill) begin
         if (c1 <= c2) scan_pass(c1, r1, c2, r2, 1'b0, fill, hit);
         else scan_pass(c2, r2, c1, r1, 1'b0, fill, hit);
         blocked = blocked | hit;
      end
   endtask

   task automatic send_query(int fr, int fc, int sr, int sc, int typed);
      bit dummy;
      scan_query(fr, fc, sr, sc, 1'b1, dummy);
      push_word(KIND_QUERY, pack_word($urandom_range(511), $urandom_range(511),
                $urandom_range(255), $urandom_range(255), $urandom_range(255),
                fr, fc, sr, sc), typed);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (clear_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_threshold(int value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[7:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      threshold = value;
   endtask

   task automatic random_phase(int mode, int th, int n_words);
      int stop_at, w, r1, c1, r2, c2, pick;
      send_idle_pct = (mode == 1) ? 85 : (mode == 3) ? 13 : 0;
      recv_stall_pct = (mode == 2) ? 85 : (mode == 3) ? 13 : 0;
      set_threshold(th);
      hot_r[0] = 0;
      hot_c[0] = 0;
      hot_r[1] = MAP_N - 16;
      hot_c[1] = MAP_N - 16;
      for (int i = 2; i < 4; i++) begin
         hot_r[i] = $urandom_range(MAP_N - 16);
         hot_c[i] = $urandom_range(MAP_N - 16);
      end
      stop_at = word_count + n_words;
      while (word_count < stop_at) begin
         w = $urandom_range(3);
         pick = $urandom_range(99);
         obst_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(20);
         if (pick < 45) begin
            r1 = hot_r[w] + $urandom_range(15);
            c1 = hot_c[w] + $urandom_range(15);
            r2 = hot_r[w] + $urandom_range(15);
            c2 = hot_c[w] + $urandom_range(15);
            send_query(r1, c1, r2, c2, TYPED_NONE);
         end else if (pick < 80) begin
            push_word(KIND_WRITE, pack_word(hot_r[w] + $urandom_range(15),
                      hot_c[w] + $urandom_range(15), color_byte(1'b1, 1'b0),
                      color_byte(1'b1, 1'b0), color_byte(1'b0, 1'b0),
                      $urandom_range(511), $urandom_range(511),
                      $urandom_range(511), $urandom_range(511)), TYPED_NONE);
         end else begin
            push_word(KIND_WRITE, pack_word($urandom_range(511), $urandom_range(511),
                      $urandom_range(255), $urandom_range(255), $urandom_range(255),
                      $urandom_range(511), $urandom_range(511),
                      $urandom_range(511), $urandom_range(511)), TYPED_NONE);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (clear_expected.size() == 0) begin
               $error("unexpected rsp word: path_clear actual %0d", rsp_tdata[0]);
               fail_count++;
            end else begin
               head_clear = clear_expected.pop_front();
               if (rsp_tdata[0] !== head_clear) begin
                  $error("path_clear expected %0d actual %0d", head_clear, rsp_tdata[0]);
                  fail_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("*** FAILED ***");
               $finish;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_WRITE;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset threshold of 250: 249 everywhere is an obstacle, a single 250 is not.
      add_row('{KIND_WRITE, 0, 0, 249, 249, 249, 0, 0, 0, 0, TYPED_NONE});
      add_row('{KIND_WRITE, 0, 1, 250, 0, 0, 0, 0, 0, 0, TYPED_NONE});
      add_row('{KIND_WRITE, 511, 511, 0, 0, 255, 0, 0, 0, 0, TYPED_NONE});
      add_row('{KIND_WRITE, 511, 510, 0, 0, 0, 0, 0, 0, 0, TYPED_NONE});
      // Equal endpoint rows are blocked, coincident points included.
      add_row('{KIND_QUERY, 0, 0, 0, 0, 0, 5, 5, 5, 5, 0});
      add_row('{KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 511, 0});
      add_row('{KIND_QUERY, 0, 0, 0, 0, 0, 511, 511, 511, 0, 0});
      // Adjacent rows in one column sample nothing and are clear.
      add_row('{KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1});
      add_row('{KIND_QUERY, 0, 0, 0, 0, 0, 511, 511, 510, 511, 1});
      add_row('{KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 2, 0, TYPED_NONE});
      add_row('{KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 3, 2, TYPED_NONE});
      // Samples in the last column reach past the map and are skipped; a query along the last row is blocked.
      add_row('{KIND_QUERY, 0, 0, 0, 0, 0, 500, 511, 509, 511, TYPED_NONE});
      add_row('{KIND_QUERY, 0, 0, 0, 0, 0, 511, 500, 511, 509, 0});
      add_row('{KIND_QUERY, 0, 0, 0, 0, 0, 505, 505, 511, 511, TYPED_NONE});
      add_row('{KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 12, 12, TYPED_NONE});
      add_row('{KIND_QUERY, 0, 0, 0, 0, 0, 511, 0, 499, 12, TYPED_NONE});
      add_row('{KIND_QUERY, 0, 0, 0, 0, 0, 10, 0, 14, 30, TYPED_NONE});
      add_row('{KIND_QUERY, 0, 0, 0, 0, 0, 20, 300, 10, 280, TYPED_NONE});

      obst_pct = 1;
      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == KIND_WRITE)
            push_word(KIND_WRITE, pack_word(dir_tab[i].pr, dir_tab[i].pc, dir_tab[i].bb,
                      dir_tab[i].gb, dir_tab[i].rb, 0, 0, 0, 0), TYPED_NONE);
         else
            send_query(dir_tab[i].fr, dir_tab[i].fc, dir_tab[i].sr, dir_tab[i].sc,
                       dir_tab[i].typed);
      end

      random_phase(0, 0, 60);
      random_phase(1, 255, 60);
      wait_drained();
      random_phase(2, 1, 60);
      random_phase(3, $urandom_range(255), 60);
      random_phase(0, $urandom_range(255), 50);
      random_phase(3, 250, 50);

      wait_drained();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
